### hdl/kbr_pkg.sv
package kbr_pkg;

  // Input word kinds
  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_HOST  = 2'd2,
    MODE_START = 2'd3
  } mode_t;

  // Result event codes
  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_LEN_OK   = 4'd1,
    EV_ACKED    = 4'd2,
    EV_DONE     = 4'd3,
    EV_BAD_END  = 4'd4,
    EV_CNT_ERR  = 4'd5,
    EV_STRAY    = 4'd6,
    EV_ECHO     = 4'd7,
    EV_KB2      = 4'd8,
    EV_SYNC     = 4'd9,
    EV_TIMEOUT  = 4'd10
  } ev_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_ONE = 2'd0;
  localparam logic [1:0] CFG_KEY_TWO = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam int          MAX_BLOCK_LEN = 64;
  localparam int          MIN_BLOCK_LEN = 3;
  localparam logic [7:0]  SYNC_BYTE     = 8'h55;
  localparam logic [7:0]  END_BYTE      = 8'h03;
  localparam logic [7:0]  COUNTER_STEP  = 8'd2;
  localparam logic [15:0] TIMEOUT_RST   = 16'd4000;

  // One result word
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [6:0] data_index;
    logic [7:0] data_byte;
    ev_t        event_res;
    logic [7:0] block_counter;
    logic [7:0] block_title;
    logic [5:0] payload_length;
    logic [7:0] next_tx_counter;
  } res_t;

endpackage

### hdl/kbr_core.sv
module kbr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_addr,
  input  logic [15:0]      cfg_wdata,
  input  logic             step,
  input  kbr_pkg::mode_t   mode,
  input  logic [7:0]       rx_byte,
  output kbr_pkg::res_t    res
);
  import kbr_pkg::*;

  logic [7:0]  key_one_r, key_two_r;
  logic [15:0] timeout_r;

  logic [6:0]  rx_pos_r, rx_pos_nxt;
  logic [6:0]  exp_len_r, exp_len_nxt;
  logic        echo_r, echo_nxt;
  logic        cnt_known_r, cnt_known_nxt;
  logic [7:0]  exp_cnt_r, exp_cnt_nxt;
  logic [7:0]  held_cnt_r, held_cnt_nxt;
  logic [7:0]  held_title_r, held_title_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        live_r, live_nxt;

  logic [15:0] idle_inc;
  logic [6:0]  len_less_min;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_one_r <= '0;
      key_two_r <= '0;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_KEY_ONE: key_one_r <= cfg_wdata[7:0];
        CFG_KEY_TWO: key_two_r <= cfg_wdata[7:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_pos_r    <= '0;
      exp_len_r   <= '0;
      echo_r      <= 1'b0;
      cnt_known_r <= 1'b0;
      exp_cnt_r   <= '0;
      idle_r      <= '0;
      live_r      <= 1'b0;
    end else begin
      rx_pos_r    <= rx_pos_nxt;
      exp_len_r   <= exp_len_nxt;
      echo_r      <= echo_nxt;
      cnt_known_r <= cnt_known_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      idle_r      <= idle_nxt;
      live_r      <= live_nxt;
    end
  end

  // Counter and title of the block in flight
  always_ff @(posedge clk) begin
    held_cnt_r   <= held_cnt_nxt;
    held_title_r <= held_title_nxt;
  end

  assign idle_inc     = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign len_less_min = exp_len_r - 7'(MIN_BLOCK_LEN);

  // Decode one word against the current state
  always_comb begin
    rx_pos_nxt     = rx_pos_r;
    exp_len_nxt    = exp_len_r;
    echo_nxt       = echo_r;
    cnt_known_nxt  = cnt_known_r;
    exp_cnt_nxt    = exp_cnt_r;
    held_cnt_nxt   = held_cnt_r;
    held_title_nxt = held_title_r;
    idle_nxt       = idle_r;
    live_nxt       = live_r;
    res            = '0;
    res.event_res  = EV_NONE;

    if (step) begin
      case (mode)
        MODE_START: begin
          rx_pos_nxt    = '0;
          exp_len_nxt   = '0;
          echo_nxt      = 1'b0;
          cnt_known_nxt = 1'b0;
          idle_nxt      = '0;
          live_nxt      = 1'b1;
        end
        MODE_HOST: begin
          idle_nxt = '0;
        end
        MODE_TICK: begin
          if (live_r) begin
            idle_nxt = idle_inc;
            if (idle_inc >= timeout_r) begin
              live_nxt      = 1'b0;
              res.event_res = EV_TIMEOUT;
            end
          end
        end
        MODE_RX: begin
          if (live_r) begin
            if (rx_pos_r == '0) begin
              // Block start: skip sync and key byte 1, answer key byte 2, take length
              if (rx_byte == SYNC_BYTE || rx_byte == key_one_r) begin
                res.event_res = EV_SYNC;
              end else if (rx_byte == key_two_r) begin
                res.tx_valid  = 1'b1;
                res.tx_byte   = ~key_two_r;
                res.event_res = EV_KB2;
              end else if (rx_byte >= 8'(MIN_BLOCK_LEN) &&
                           rx_byte <= 8'(MAX_BLOCK_LEN)) begin
                exp_len_nxt    = rx_byte[6:0];
                rx_pos_nxt     = 7'd1;
                echo_nxt       = 1'b1;
                res.tx_valid   = 1'b1;
                res.tx_byte    = ~rx_byte;
                res.data_valid = 1'b1;
                res.data_byte  = rx_byte;
                res.event_res  = EV_LEN_OK;
              end else begin
                res.event_res = EV_STRAY;
              end
            end else if (echo_r) begin
              // Drop the echo of our acknowledge
              echo_nxt      = 1'b0;
              res.event_res = EV_ECHO;
            end else begin
              if (rx_pos_r == 7'd1) held_cnt_nxt = rx_byte;
              if (rx_pos_r == 7'd2) held_title_nxt = rx_byte;
              rx_pos_nxt = rx_pos_r + 7'd1;
              if (rx_pos_r < exp_len_r) begin
                echo_nxt       = 1'b1;
                res.tx_valid   = 1'b1;
                res.tx_byte    = ~rx_byte;
                res.data_valid = 1'b1;
                res.data_index = rx_pos_r;
                res.data_byte  = rx_byte;
                res.event_res  = EV_ACKED;
              end else if (rx_byte != END_BYTE) begin
                rx_pos_nxt    = '0;
                exp_len_nxt   = '0;
                echo_nxt      = 1'b0;
                res.event_res = EV_BAD_END;
              end else if (cnt_known_r && held_cnt_r != exp_cnt_r) begin
                rx_pos_nxt    = '0;
                exp_len_nxt   = '0;
                echo_nxt      = 1'b0;
                live_nxt      = 1'b0;
                res.event_res = EV_CNT_ERR;
              end else begin
                cnt_known_nxt       = 1'b1;
                exp_cnt_nxt         = held_cnt_r + COUNTER_STEP;
                res.event_res       = EV_DONE;
                res.block_counter   = held_cnt_r;
                res.block_title     = held_title_r;
                res.payload_length  = len_less_min[5:0];
                res.next_tx_counter = held_cnt_r + 8'd1;
                rx_pos_nxt          = '0;
                exp_len_nxt         = '0;
                echo_nxt            = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Session ends after a timeout or a counter mismatch
  a_session_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && (res.event_res == EV_TIMEOUT || res.event_res == EV_CNT_ERR)
    |=> !live_r)
    else $error("session still live after timeout or counter error");

  // Session start leaves a clean block and timer
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode == MODE_START |=> live_r && rx_pos_r == '0 && idle_r == '0 && !echo_r)
    else $error("session start did not clear block state");

  // An accepted length arms the echo drop at position one
  a_len_echo: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.event_res == EV_LEN_OK |=> echo_r && rx_pos_r == 7'd1)
    else $error("length byte did not arm echo drop");

  // An echo is only expected inside a block
  a_echo_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    echo_r |-> rx_pos_r != '0)
    else $error("echo pending outside a block");

endmodule

### hdl/kline_block_receiver.sv
// Channel   Direction  Payload
// in_       slave      tuser: mode; tdata: rx_byte
// out_      master     tuser: tx_valid, data_valid, event_res; tdata: result bytes
// cfg_      write      index 0 key_byte_one, 1 key_byte_two, 2 session_timeout_ticks
//
// One word per cycle sustained while out_tready is high; a word is accepted into the input
// register and is then decoded into the result register.
// The decode of a word reads the receiver state left by the word just before.
// rst_n is synchronous; no clearing pass, the block accepts words right away.
// A stall on out_tready holds the result and backs up into in_tready.
module kline_block_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] tx_byte, [14:8] data_index, [22:15] data_byte, [30:23] block_counter,
  // [38:31] block_title, [44:39] payload_length, [52:45] next_tx_counter
  output logic [55:0] out_tdata,
  output logic [5:0]  out_tuser,  // [0] tx_valid, [1] data_valid, [5:2] event_res
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import kbr_pkg::*;

  logic       s1_valid_r;
  mode_t      s1_mode_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       res;
  logic       adv;
  logic       in_acc;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= mode_t'(in_tuser);
      s1_byte_r <= in_tdata;
    end
  end

  kbr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (adv),
    .mode      (s1_mode_r),
    .rx_byte   (s1_byte_r),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  // Pack the result word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.next_tx_counter, out_res_r.payload_length,
                       out_res_r.block_title, out_res_r.block_counter,
                       out_res_r.data_byte, out_res_r.data_index, out_res_r.tx_byte};
  assign out_tuser  = {out_res_r.event_res, out_res_r.data_valid, out_res_r.tx_valid};

endmodule
